// ----- src/pei_pkg.sv -----
`default_nettype none
package pei_pkg;

  localparam int FRAC_BITS = 16;     // fraction bits of position, velocity, force, inv_mass
  localparam int DUR_FRAC  = 16;     // duration is Q0.16
  localparam int ROOT_W    = 31;     // Q0.30 root constants

  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_INTEG = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;
  localparam logic [1:0] FUNC_PLACE = 2'd3;

  localparam logic [2:0] REG_INV_MASS = 3'd0;
  localparam logic [2:0] REG_DAMPING  = 3'd1;
  localparam logic [2:0] REG_ACCEL_X  = 3'd2;
  localparam logic [2:0] REG_ACCEL_Y  = 3'd3;
  localparam logic [2:0] REG_ACCEL_Z  = 3'd4;

  localparam logic [16:0] DAMP_ONE = 17'd65536;

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sd2147483647) r = 32'h7fff_ffff;
    else if (v < -64'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // floor square root, evaluated at elaboration only
  function automatic logic [63:0] isqrt_c(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    v = v_in;
    res = 64'd0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // entry i holds 2^(-2^-(i+1)) in Q0.30
  function automatic logic [16*ROOT_W-1:0] root_table();
    logic [16*ROOT_W-1:0] tab;
    logic [63:0] r;
    tab = '0;
    r = isqrt_c(64'd1 << 59);
    for (int i = 0; i < 16; i++) begin
      tab[i*ROOT_W +: ROOT_W] = r[ROOT_W-1:0];
      r = isqrt_c(r << 30);
    end
    return tab;
  endfunction

  localparam logic [16*ROOT_W-1:0] ROOT_TAB = root_table();

endpackage
`default_nettype wire

// ----- src/pei_mul.sv -----
`default_nettype none
module pei_mul (
  input  wire logic               clk,
  input  wire logic signed [32:0] a,
  input  wire logic signed [32:0] b,
  output logic signed [63:0]      p_r
);
  logic signed [65:0] full;

  assign full = a * b;

  always_ff @(posedge clk) begin
    p_r <= full[63:0];
  end
endmodule
`default_nettype wire

// ----- src/particle_euler_integrator.sv -----
`default_nettype none
// Euler integrator for one particle with damping. One beat in, one beat out.
// Add force, clear force and place present their result in the cycle after
// the accept. Integrate runs these steps in order: the 16 squarings of log2
// of damping, the exponent multiply, the 16 root multiplies of the power, the
// shift that gives the gain, the 4 multiplies per axis, then the output state.
// All of it runs on one registered 33x33 multiplier, each multiply being
// issued and its registered product then consumed. Zero damping skips the
// logarithm and the power (gain zero); zero inverse mass skips everything
// (result in the cycle after the accept). in_tready is low while an item is
// in work or its result waits, so a stalled receiver adds its stall.
// Configuration writes are accepted every cycle.
module particle_euler_integrator (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [111:0] in_tdata,   // vec_x, vec_y, vec_z, duration
  input  wire logic [1:0]   in_tuser,   // func
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [191:0]      out_tdata,  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);
  import pei_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOG  = 3'd1;
  localparam logic [2:0] S_T    = 3'd2;
  localparam logic [2:0] S_EXP  = 3'd3;
  localparam logic [2:0] S_G    = 3'd4;
  localparam logic [2:0] S_COMP = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]  state_r;
  logic [3:0]  cnt_r;
  logic        ph_r;
  logic [1:0]  k_r;
  logic [31:0] pos_r [3];
  logic [31:0] vel_r [3];
  logic [31:0] frc_r [3];
  logic [31:0] acfg_r [3];
  logic [31:0] inv_mass_r;
  logic [16:0] damp_r;
  logic [15:0] dur_r;
  logic [15:0] x_r;
  logic [15:0] frac_r;
  logic [4:0]  p_r;
  logic [30:0] prod_r;
  logic [16:0] g_r;
  logic [31:0] acc_r;
  logic [31:0] v_r;

  logic signed [32:0] mul_a, mul_b;
  logic signed [63:0] mul_p;

  logic [1:0]  func;
  logic [31:0] vec [3];
  logic [15:0] in_dur;
  logic [16:0] dclamp;
  logic [4:0]  ptop;
  logic [15:0] xnorm;
  logic [31:0] dsh;
  logic [16:0] xsq;
  logic [20:0] nlog;
  logic [20:0] tval;
  logic [30:0] root;
  logic [30:0] pshift;

  assign func   = in_tuser;
  assign vec[0] = in_tdata[31:0];
  assign vec[1] = in_tdata[63:32];
  assign vec[2] = in_tdata[95:64];
  assign in_dur = in_tdata[111:96];

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign cfg_ready  = 1'b1;
  assign out_tdata  = {vel_r[2], vel_r[1], vel_r[0], pos_r[2], pos_r[1], pos_r[0]};

  // damping clamp and normalization to Q1.15
  always_comb begin
    dclamp = (damp_r > DAMP_ONE) ? DAMP_ONE : damp_r;
    ptop = 5'd0;
    for (int i = 1; i < 17; i++) begin
      if (dclamp[i]) ptop = 5'(i);
    end
    dsh = 32'(dclamp) << (5'd15 - ptop);
    xnorm = (ptop == 5'd16) ? 16'h8000 : dsh[15:0];
  end

  assign xsq    = mul_p[31:15];
  assign nlog   = {(5'd16 - p_r), 16'd0} - {5'd0, frac_r};
  assign tval   = mul_p[36:16];
  assign root   = ROOT_TAB[cnt_r*ROOT_W +: ROOT_W];
  assign pshift = prod_r >> p_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_LOG: begin
        mul_a = {17'd0, x_r};
        mul_b = {17'd0, x_r};
      end
      S_T: begin
        mul_a = {17'd0, dur_r};
        mul_b = {12'd0, nlog};
      end
      S_EXP: begin
        mul_a = {2'd0, prod_r};
        mul_b = {2'd0, root};
      end
      S_COMP: begin
        unique case (cnt_r[1:0])
          2'd0: begin
            mul_a = {vel_r[k_r][31], vel_r[k_r]};
            mul_b = {17'd0, dur_r};
          end
          2'd1: begin
            mul_a = {frc_r[k_r][31], frc_r[k_r]};
            mul_b = {1'b0, inv_mass_r};
          end
          2'd2: begin
            mul_a = {acc_r[31], acc_r};
            mul_b = {17'd0, dur_r};
          end
          default: begin
            mul_a = {v_r[31], v_r};
            mul_b = {16'd0, g_r};
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  pei_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      ph_r       <= 1'b0;
      k_r        <= '0;
      inv_mass_r <= 32'd65536;
      damp_r     <= DAMP_ONE;
      for (int k = 0; k < 3; k++) begin
        pos_r[k]  <= '0;
        vel_r[k]  <= '0;
        frc_r[k]  <= '0;
        acfg_r[k] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_INV_MASS: inv_mass_r <= cfg_data;
          REG_DAMPING:  damp_r <= cfg_data[16:0];
          REG_ACCEL_X:  acfg_r[0] <= cfg_data;
          REG_ACCEL_Y:  acfg_r[1] <= cfg_data;
          REG_ACCEL_Z:  acfg_r[2] <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            state_r <= S_OUT;
            unique case (func)
              FUNC_ADD: begin
                for (int k = 0; k < 3; k++)
                  frc_r[k] <= sat32(64'(signed'(frc_r[k])) + 64'(signed'(vec[k])));
              end
              FUNC_CLEAR: begin
                for (int k = 0; k < 3; k++) frc_r[k] <= '0;
              end
              FUNC_PLACE: begin
                for (int k = 0; k < 3; k++) begin
                  pos_r[k] <= vec[k];
                  vel_r[k] <= '0;
                  frc_r[k] <= '0;
                end
              end
              default: begin
                if (inv_mass_r != 32'd0) begin
                  dur_r  <= in_dur;
                  p_r    <= ptop;
                  x_r    <= xnorm;
                  frac_r <= '0;
                  cnt_r  <= '0;
                  ph_r   <= 1'b0;
                  k_r    <= '0;
                  if (dclamp == 17'd0) begin
                    g_r     <= '0;
                    state_r <= S_COMP;
                  end else begin
                    state_r <= S_LOG;
                  end
                end
              end
            endcase
          end
        end
        S_LOG: begin
          ph_r <= ~ph_r;
          if (ph_r) begin
            if (xsq[16]) begin
              x_r <= xsq[16:1];
              frac_r[4'd15 - cnt_r] <= 1'b1;
            end else begin
              x_r <= xsq[15:0];
            end
            cnt_r <= cnt_r + 4'd1;
            if (cnt_r == 4'd15) state_r <= S_T;
          end
        end
        S_T: begin
          ph_r <= ~ph_r;
          if (ph_r) begin
            frac_r  <= tval[15:0];
            p_r     <= tval[20:16];
            prod_r  <= 31'd1 << 30;
            cnt_r   <= '0;
            state_r <= S_EXP;
          end
        end
        S_EXP: begin
          ph_r <= ~ph_r;
          if (ph_r) begin
            if (frac_r[4'd15 - cnt_r]) prod_r <= mul_p[60:30];
            cnt_r <= cnt_r + 4'd1;
            if (cnt_r == 4'd15) state_r <= S_G;
          end
        end
        S_G: begin
          g_r     <= pshift[30:14];
          cnt_r   <= '0;
          state_r <= S_COMP;
        end
        S_COMP: begin
          ph_r <= ~ph_r;
          if (ph_r) begin
            cnt_r <= cnt_r + 4'd1;
            unique case (cnt_r[1:0])
              2'd0: pos_r[k_r] <= sat32(64'(signed'(pos_r[k_r])) + (mul_p >>> DUR_FRAC));
              2'd1: acc_r <= sat32(64'(signed'(acfg_r[k_r])) + (mul_p >>> FRAC_BITS));
              2'd2: v_r <= sat32(64'(signed'(vel_r[k_r])) + (mul_p >>> DUR_FRAC));
              default: begin
                vel_r[k_r] <= sat32(mul_p >>> DUR_FRAC);
                frc_r[k_r] <= '0;
                k_r <= k_r + 2'd1;
                if (k_r == 2'd2) state_r <= S_OUT;
              end
            endcase
          end
        end
        S_OUT: begin
          if (out_tready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_tvalid && in_tready))
    else $error("input accepted while result pending");

  a_short_ops: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && func != FUNC_INTEG) |=> out_tvalid)
    else $error("short operation did not complete in one cycle");

  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMP) |-> (g_r <= DAMP_ONE))
    else $error("damping gain above one");

  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMP) |-> (k_r != 2'd3))
    else $error("axis counter out of range");

endmodule
`default_nettype wire

// ----- verif/pei_checker.sv -----
`timescale 1ns / 100ps
module pei_checker (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [111:0] in_tdata,
  input  wire logic [1:0]   in_tuser,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [191:0] out_tdata,
  input  wire logic         cfg_valid,
  input  wire logic         cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data,
  output int                fail_count,
  output int                pending
);
  import pei_pkg::*;

  typedef logic signed [31:0] fix_t;

  logic [31:0]  mass_inv;
  logic [16:0]  damp;
  fix_t         acc_cfg [3];
  fix_t         pos [3];
  fix_t         vel [3];
  fix_t         frc [3];
  logic [191:0] state_q [$];

  function automatic logic signed [63:0] clip32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] rem, res, b;
    rem = v;
    res = 0;
    b = 64'd1 << 62;
    while (b > rem && b != 0) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // damping raised to the step length, Q1.16
  function automatic logic [63:0] decay_gain(input logic [16:0] d_in, input logic [15:0] dur);
    logic [63:0] d, x, frac, n, t, f, q, prod, r;
    int p;
    d = (d_in > DAMP_ONE) ? 64'(DAMP_ONE) : 64'(d_in);
    if (d == 0) return 0;
    p = 0;
    while (p < 16 && (d >> (p + 1)) != 0) p++;
    x = (p <= 15) ? (d << (15 - p)) : (d >> (p - 15));
    frac = 0;
    for (int i = 1; i <= 16; i++) begin
      x = (x * x) >> 15;
      if (x >= 65536) begin
        x = x >> 1;
        frac = frac | (64'd1 << (16 - i));
      end
    end
    n = 64'(16 - p) * 65536 - frac;
    t = (64'(dur) * n) >> 16;
    q = t >> 16;
    f = t & 64'hFFFF;
    prod = 64'd1 << 30;
    r = floor_root(64'd1 << 59);
    for (int i = 1; i <= 16; i++) begin
      if ((f >> (16 - i)) & 1) prod = (prod * r) >> 30;
      r = floor_root(r << 30);
    end
    prod = (q < 63) ? (prod >> q) : 0;
    return prod >> 14;
  endfunction

  task automatic step_particle(input logic [1:0] op, input logic [111:0] d);
    fix_t vec [3];
    logic signed [63:0] a, v, g;
    logic [15:0] dur;
    dur = d[111:96];
    for (int k = 0; k < 3; k++) vec[k] = d[32*k +: 32];
    case (op)
      FUNC_ADD: begin
        for (int k = 0; k < 3; k++) frc[k] = fix_t'(clip32(64'(frc[k]) + 64'(vec[k])));
      end
      FUNC_INTEG: begin
        if (mass_inv != 0) begin
          g = signed'(decay_gain(damp, dur));
          for (int k = 0; k < 3; k++) begin
            pos[k] = fix_t'(clip32(64'(pos[k]) + ((64'(vel[k]) * signed'(64'(dur))) >>> 16)));
            a = (64'(frc[k]) * signed'(64'(mass_inv))) >>> FRAC_BITS;
            a = clip32(64'(acc_cfg[k]) + a);
            v = clip32(64'(vel[k]) + ((a * signed'(64'(dur))) >>> 16));
            vel[k] = fix_t'(clip32((v * g) >>> 16));
            frc[k] = 0;
          end
        end
      end
      FUNC_CLEAR: begin
        for (int k = 0; k < 3; k++) frc[k] = 0;
      end
      default: begin
        for (int k = 0; k < 3; k++) begin
          pos[k] = vec[k];
          vel[k] = 0;
          frc[k] = 0;
        end
      end
    endcase
    state_q.push_back({vel[2], vel[1], vel[0], pos[2], pos[1], pos[0]});
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mass_inv <= 32'd65536;
      damp <= DAMP_ONE;
      for (int k = 0; k < 3; k++) begin
        acc_cfg[k] = 0;
        pos[k] = 0;
        vel[k] = 0;
        frc[k] = 0;
      end
      state_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_INV_MASS: mass_inv <= cfg_data;
          REG_DAMPING:  damp <= cfg_data[16:0];
          REG_ACCEL_X:  acc_cfg[0] = cfg_data;
          REG_ACCEL_Y:  acc_cfg[1] = cfg_data;
          REG_ACCEL_Z:  acc_cfg[2] = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) step_particle(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        if (state_q.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          logic [191:0] want;
          int errs;
          want = state_q.pop_front();
          errs = 0;
          for (int f = 0; f < 6; f++) begin
            if (out_tdata[32*f +: 32] !== want[32*f +: 32]) begin
              $display("%0t: field %0d expected %h actual %h", $time, f,
                       want[32*f +: 32], out_tdata[32*f +: 32]);
              errs++;
            end
          end
          fail_count <= fail_count + errs;
        end
      end
    end
  end

  assign pending = state_q.size();

endmodule

// ----- verif/tb_particle_euler_integrator.sv -----
`timescale 1ns / 100ps
module tb_particle_euler_integrator;
  import pei_pkg::*;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [111:0] in_tdata;   // vec_x, vec_y, vec_z, duration
  logic [1:0]   in_tuser;   // func
  logic         out_tvalid;
  logic         out_tready;
  logic [191:0] out_tdata;  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [31:0]  cfg_data;
  int           fail_count;
  int           pending;
  int           hold_cycles;
  bit           stall_mode;

  particle_euler_integrator i_dut (.*);

  pei_checker i_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 8) << 16;
      3: return -($urandom_range(0, 8) << 16);
      default: return $urandom;
    endcase
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  task automatic send_item(input logic [1:0] op, input logic [31:0] x, input logic [31:0] y,
                           input logic [31:0] z, input logic [15:0] dur);
    int gap;
    gap = stall_mode ? 0 : pick_gap();
    repeat (gap) @(negedge clk);
    in_tvalid <= 1;
    in_tuser <= op;
    in_tdata <= {dur, z, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    in_tvalid <= 0;
    @(negedge clk);
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic random_op(input int integ_weight);
    logic [1:0] op;
    logic [15:0] dur;
    int r;
    r = $urandom_range(0, 99);
    if (r < integ_weight) op = FUNC_INTEG;
    else if (r < integ_weight + 40) op = FUNC_ADD;
    else if (r < integ_weight + 48) op = FUNC_CLEAR;
    else op = FUNC_PLACE;
    dur = ($urandom_range(0, 9) == 0) ? 16'hffff : 16'($urandom_range(1, 65535));
    if ($urandom_range(0, 9) == 0) dur = 16'($urandom);
    send_item(op, pick_word(), pick_word(), pick_word(), dur);
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    out_tready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 0;
        hold_cycles--;
      end else if ($urandom_range(0, 9) < 3) begin
        out_tready <= 0;
        repeat (pick_gap()) @(negedge clk);
      end else begin
        out_tready <= 1;
      end
    end
  end

  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = FUNC_ADD;
    cfg_valid = 0;
    cfg_index = REG_INV_MASS;
    cfg_data = 0;
    hold_cycles = 0;
    stall_mode = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: every operation, field extremes, unit and zero damping, infinite mass
    send_item(FUNC_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 16'd0);
    send_item(FUNC_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 16'hffff);
    send_item(FUNC_INTEG, 0, 0, 0, 16'hffff);
    send_item(FUNC_INTEG, 0, 0, 0, 16'd1);
    send_item(FUNC_PLACE, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 16'h5555);
    send_item(FUNC_ADD, 32'h0100_0000, 32'hff00_0000, 32'h12_3456, 16'haaaa);
    send_item(FUNC_CLEAR, 32'hffff_ffff, 0, 0, 16'd0);
    send_item(FUNC_ADD, 32'h0100_0000, 32'hff00_0000, 32'h12_3456, 16'd0);
    send_item(FUNC_INTEG, 0, 0, 0, 16'h8000);
    send_item(FUNC_INTEG, 0, 0, 0, 16'h0);
    drain();
    write_reg(REG_DAMPING, 32'd0);
    write_reg(REG_ACCEL_X, 32'h7fff_ffff);
    write_reg(REG_ACCEL_Y, 32'h8000_0000);
    write_reg(REG_ACCEL_Z, 32'h0000_8000);
    send_item(FUNC_INTEG, 0, 0, 0, 16'hffff);
    drain();
    write_reg(REG_DAMPING, 32'h1_ffff);
    write_reg(REG_INV_MASS, 32'hffff_ffff);
    send_item(FUNC_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h1, 16'd0);
    send_item(FUNC_INTEG, 0, 0, 0, 16'hffff);
    drain();
    write_reg(REG_INV_MASS, 32'd0);
    send_item(FUNC_ADD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 16'd0);
    send_item(FUNC_INTEG, 0, 0, 0, 16'h1234);
    send_item(FUNC_PLACE, 32'h0001_0000, 32'h0, 32'hffff_0000, 16'd0);
    drain();

    // random phases, each with its own register setting
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(REG_INV_MASS, (ph % 6 == 5) ? 32'd0 :
                ($urandom_range(0, 1) ? 32'($urandom_range(1, 4) << 16) : $urandom));
      write_reg(REG_DAMPING, (ph % 4 == 0) ? 32'(DAMP_ONE) :
                (ph % 4 == 1) ? 32'($urandom_range(0, 3)) : 32'($urandom_range(0, 131071)));
      write_reg(REG_ACCEL_X, pick_word());
      write_reg(REG_ACCEL_Y, pick_word());
      write_reg(REG_ACCEL_Z, pick_word());
      if (ph == 3) begin
        // stall output so the block backs up and holds off input
        hold_cycles = 400;
        stall_mode = 1;
        for (int i = 0; i < 20; i++) random_op(30);
        stall_mode = 0;
      end
      for (int i = 0; i < 120; i++) random_op((ph % 3 == 0) ? 10 : 35);
      drain();
    end

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- particle_euler_integrator.f -----
src/pei_pkg.sv
src/pei_mul.sv
src/particle_euler_integrator.sv
verif/pei_checker.sv
verif/tb_particle_euler_integrator.sv
